// ===== hdl/mpf_pkg.sv =====
// Package for the MAVLink packet framer with statistics.
// Holds phase and controller state types, constants and the X.25 CRC step.
// No dependencies.
package mpf_pkg;

    localparam int          SOURCE_SLOTS_DEF = 10;
    localparam logic [7:0]  START_MARK       = 8'd254;
    localparam logic [15:0] CRC_SEED         = 16'hFFFF;
    localparam logic        ACT_STREAM       = 1'b0;
    localparam logic        ACT_LOAD         = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ===== hdl/mpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mpf_ctrl.sv =====
// Controller for the framer: sequences accept, slot lookup and slot update.
// Depends on mpf_pkg.
module mpf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mpf_pkg::dp_status_t status,
    output mpf_pkg::ctrl_cmd_t  cmd
);

    mpf_pkg::ctrl_state_t state_reg, state_next;
    logic accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpf_pkg::ST_IDLE:
            begin
                if (accept && status.is_last)
                begin
                    state_next = mpf_pkg::ST_LOOKUP;
                end
            end
            mpf_pkg::ST_LOOKUP: state_next = mpf_pkg::ST_UPDATE;
            mpf_pkg::ST_UPDATE: state_next = mpf_pkg::ST_IDLE;
            default:            state_next = mpf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.lookup = 1'b0;
        cmd.update = 1'b0;
        unique case (state_reg)
            mpf_pkg::ST_IDLE:
            begin
                in_ready   = status.out_free;
                cmd.accept = accept;
            end
            mpf_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
            mpf_pkg::ST_UPDATE: cmd.update = 1'b1;
            default:            in_ready   = 1'b0;
        endcase
    end

endmodule

// ===== hdl/mpf_dpath.sv =====
// Datapath for the framer: framing, CRC, totals, source slots, output register.
// Depends on mpf_pkg and mpf_ram.
module mpf_dpath #(
    parameter int SOURCE_SLOTS = mpf_pkg::SOURCE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpf_pkg::ctrl_cmd_t  cmd,
    output mpf_pkg::dp_status_t status,
    input  logic               action,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         table_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               first_of_packet,
    output logic               last_of_packet,
    output logic               crc_ok,
    output logic [3:0]         source_slot,
    output logic               source_overflow,
    output logic [31:0]        packet_count,
    output logic [31:0]        crc_error_count,
    output logic [31:0]        discarded_count,
    output logic [31:0]        sources_seen,
    output logic [31:0]        slot_packet_count,
    output logic [31:0]        slot_error_count
);

    localparam int SLOT_W = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;

    mpf_pkg::phase_t phase_reg;
    logic [8:0]  pos_reg;
    logic [7:0]  len_reg, msg_reg, sys_reg, comp_reg, crc_lo_reg, crc_hi_reg;
    logic [15:0] crc_reg;
    logic [31:0] tot_pk_reg, tot_err_reg, tot_disc_reg, tot_src_reg;

    logic              in_use_reg [SOURCE_SLOTS];
    logic [15:0]       key_reg    [SOURCE_SLOTS];
    logic [SLOT_W-1:0] idx_reg;
    logic              ok_reg, ovf_reg, new_reg;

    logic              out_valid_reg, first_reg, last_reg, oko_reg, ovfo_reg;
    logic [7:0]        byte_reg;
    logic [3:0]        slot_o_reg;
    logic [31:0]       spk_reg, ser_reg;

    logic [7:0]        tbl_rdata;
    logic [63:0]       cnt_rdata, cnt_wdata;
    logic [31:0]       spk_next, ser_next;
    logic              tbl_we, stream, load_plain, out_free;
    logic [15:0]       calc, key;
    logic              ok_now, hit_found, free_found;
    logic [SLOT_W-1:0] hit_idx, free_idx;
    logic [SLOT_W+3:0] idx_ext;

    assign stream     = cmd.accept && (action == mpf_pkg::ACT_STREAM);
    assign tbl_we     = cmd.accept && (action == mpf_pkg::ACT_LOAD);
    assign out_free   = !out_valid_reg || out_ready;
    assign status.is_last  = (action == mpf_pkg::ACT_STREAM) && (phase_reg == mpf_pkg::PH_CRC_HI);
    assign status.out_free = out_free;

    assign load_plain = stream && (phase_reg != mpf_pkg::PH_CRC_HI)
                        && !((phase_reg == mpf_pkg::PH_HUNT) && (data_byte != mpf_pkg::START_MARK));

    mpf_ram #(.WIDTH(8), .DEPTH(256)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (table_index),
        .wdata (data_byte),
        .raddr (msg_reg),
        .rdata (tbl_rdata)
    );

    mpf_ram #(.WIDTH(64), .DEPTH(SOURCE_SLOTS)) u_cnt (
        .clk   (clk),
        .we    (cmd.update && !ovf_reg),
        .waddr (idx_reg),
        .wdata (cnt_wdata),
        .raddr (hit_found ? hit_idx : free_idx),
        .rdata (cnt_rdata)
    );

    assign calc   = mpf_pkg::crc_add(crc_reg, tbl_rdata);
    assign ok_now = (calc == {crc_hi_reg, crc_lo_reg});
    assign key    = {sys_reg, comp_reg};

    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int s = 0; s < SOURCE_SLOTS; s++)
        begin
            if (in_use_reg[s])
            begin
                if (!hit_found && (key_reg[s] == key))
                begin
                    hit_found = 1'b1;
                    hit_idx   = SLOT_W'(s);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    assign spk_next  = (new_reg ? 32'd0 : cnt_rdata[63:32]) + 32'd1;
    assign ser_next  = (new_reg ? 32'd0 : cnt_rdata[31:0]) + {31'd0, !ok_reg};
    assign cnt_wdata = {spk_next, ser_next};
    assign idx_ext   = {4'b0000, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mpf_pkg::PH_HUNT;
            pos_reg      <= '0;
            len_reg      <= '0;
            msg_reg      <= '0;
            sys_reg      <= '0;
            comp_reg     <= '0;
            crc_lo_reg   <= '0;
            crc_hi_reg   <= '0;
            crc_reg      <= mpf_pkg::CRC_SEED;
            tot_pk_reg   <= '0;
            tot_err_reg  <= '0;
            tot_disc_reg <= '0;
            tot_src_reg  <= '0;
            idx_reg      <= '0;
            ok_reg       <= 1'b0;
            ovf_reg      <= 1'b0;
            new_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SOURCE_SLOTS; s++)
            begin
                in_use_reg[s] <= 1'b0;
                key_reg[s]    <= '0;
            end
        end
        else
        begin
            if (stream)
            begin
                unique case (phase_reg)
                    mpf_pkg::PH_HUNT:
                    begin
                        if (data_byte != mpf_pkg::START_MARK)
                        begin
                            tot_disc_reg <= tot_disc_reg + 32'd1;
                        end
                        else
                        begin
                            crc_reg   <= mpf_pkg::CRC_SEED;
                            pos_reg   <= 9'd1;
                            phase_reg <= mpf_pkg::PH_HEADER;
                        end
                    end
                    mpf_pkg::PH_HEADER:
                    begin
                        crc_reg <= mpf_pkg::crc_add(crc_reg, data_byte);
                        if (pos_reg == 9'd1) len_reg  <= data_byte;
                        if (pos_reg == 9'd3) sys_reg  <= data_byte;
                        if (pos_reg == 9'd4) comp_reg <= data_byte;
                        if (pos_reg == 9'd5) msg_reg  <= data_byte;
                        if (pos_reg >= 9'd5)
                        begin
                            phase_reg <= (len_reg == 8'd0) ? mpf_pkg::PH_CRC_LO
                                                           : mpf_pkg::PH_PAYLOAD;
                        end
                        pos_reg <= pos_reg + 9'd1;
                    end
                    mpf_pkg::PH_PAYLOAD:
                    begin
                        crc_reg <= mpf_pkg::crc_add(crc_reg, data_byte);
                        if (pos_reg >= (9'd5 + {1'b0, len_reg}))
                        begin
                            phase_reg <= mpf_pkg::PH_CRC_LO;
                        end
                        pos_reg <= pos_reg + 9'd1;
                    end
                    mpf_pkg::PH_CRC_LO:
                    begin
                        crc_lo_reg <= data_byte;
                        pos_reg    <= pos_reg + 9'd1;
                        phase_reg  <= mpf_pkg::PH_CRC_HI;
                    end
                    mpf_pkg::PH_CRC_HI:
                    begin
                        crc_hi_reg <= data_byte;
                        pos_reg    <= '0;
                        phase_reg  <= mpf_pkg::PH_HUNT;
                    end
                    default: phase_reg <= mpf_pkg::PH_HUNT;
                endcase
            end

            if (cmd.lookup)
            begin
                ok_reg      <= ok_now;
                tot_pk_reg  <= tot_pk_reg + 32'd1;
                tot_err_reg <= tot_err_reg + {31'd0, !ok_now};
                new_reg     <= !hit_found && free_found;
                ovf_reg     <= !hit_found && !free_found;
                idx_reg     <= hit_found ? hit_idx : free_idx;
                if (!hit_found)
                begin
                    tot_src_reg <= tot_src_reg + 32'd1;
                    if (free_found)
                    begin
                        in_use_reg[free_idx] <= 1'b1;
                        key_reg[free_idx]    <= key;
                    end
                end
            end

            if (load_plain || cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_plain)
        begin
            byte_reg   <= data_byte;
            first_reg  <= (phase_reg == mpf_pkg::PH_HUNT);
            last_reg   <= 1'b0;
            oko_reg    <= 1'b0;
            ovfo_reg   <= 1'b0;
            slot_o_reg <= '0;
            spk_reg    <= '0;
            ser_reg    <= '0;
        end
        else if (cmd.update)
        begin
            byte_reg   <= crc_hi_reg;
            first_reg  <= 1'b0;
            last_reg   <= 1'b1;
            oko_reg    <= ok_reg;
            ovfo_reg   <= ovf_reg;
            slot_o_reg <= ovf_reg ? 4'd0 : idx_ext[3:0];
            spk_reg    <= ovf_reg ? 32'd0 : spk_next;
            ser_reg    <= ovf_reg ? 32'd0 : ser_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = byte_reg;
    assign first_of_packet   = first_reg;
    assign last_of_packet    = last_reg;
    assign crc_ok            = oko_reg;
    assign source_slot       = slot_o_reg;
    assign source_overflow   = ovfo_reg;
    assign packet_count      = tot_pk_reg;
    assign crc_error_count   = tot_err_reg;
    assign discarded_count   = tot_disc_reg;
    assign sources_seen      = tot_src_reg;
    assign slot_packet_count = spk_reg;
    assign slot_error_count  = ser_reg;

endmodule

// ===== hdl/mavlink_packet_framer_stats_top.sv =====
// Top level of the MAVLink v1 packet framer with statistics.
// Depends on mpf_pkg, mpf_ctrl, mpf_dpath (which uses mpf_ram).
//
//   channel  handshake             payload
//   input    in_valid / in_ready   action, data_byte, table_index
//   output   out_valid / out_ready out_byte ... slot_error_count
//
// A table load, a discarded byte or a packet byte other than the last is taken in ST_IDLE alone.
// The last CRC byte is followed by ST_LOOKUP (CRC-extra check with slot search), then
// ST_UPDATE (the read-modify-write of the slot counter memory).
// Reset clears framing, totals and slot ownership; the CRC-extra table is not cleared.
// A new beat is taken only when the output register is empty or being drained.
module mavlink_packet_framer_stats_top #(
    parameter int SOURCE_SLOTS = mpf_pkg::SOURCE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  table_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        first_of_packet,
    output logic        last_of_packet,
    output logic        crc_ok,
    output logic [3:0]  source_slot,
    output logic        source_overflow,
    output logic [31:0] packet_count,
    output logic [31:0] crc_error_count,
    output logic [31:0] discarded_count,
    output logic [31:0] sources_seen,
    output logic [31:0] slot_packet_count,
    output logic [31:0] slot_error_count
);

    mpf_pkg::ctrl_cmd_t  cmd;
    mpf_pkg::dp_status_t status;

    mpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mpf_dpath #(.SOURCE_SLOTS(SOURCE_SLOTS)) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .action            (action),
        .data_byte         (data_byte),
        .table_index       (table_index),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .first_of_packet   (first_of_packet),
        .last_of_packet    (last_of_packet),
        .crc_ok            (crc_ok),
        .source_slot       (source_slot),
        .source_overflow   (source_overflow),
        .packet_count      (packet_count),
        .crc_error_count   (crc_error_count),
        .discarded_count   (discarded_count),
        .sources_seen      (sources_seen),
        .slot_packet_count (slot_packet_count),
        .slot_error_count  (slot_error_count)
    );

endmodule
